[rtl/imufai_pkg.sv]
// Shared constants, frame and result types for the IMU frame averager and gyro integrator.
package imufai_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned GAIN_W       = 8;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned CELSIUS_W    = 25;
  localparam int unsigned NUM_CHAN     = 4;
  localparam int unsigned NUM_GYRO     = 3;
  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned WINDOW_LOG2  = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W        = SAMPLE_W + WINDOW_LOG2;
  localparam int unsigned PROD_W       = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned FRAME_W      = 7 * SAMPLE_W;
  localparam int unsigned RESULT_RAW_W = 4 * SAMPLE_W + CELSIUS_W + 3 * TOTAL_W;
  localparam int unsigned RESULT_W     = ((RESULT_RAW_W + 7) / 8) * 8;
  localparam int unsigned PAD_W        = RESULT_W - RESULT_RAW_W;

  localparam logic [GAIN_W-1:0]           GAIN_RESET  = GAIN_W'(5);
  localparam logic signed [CELSIUS_W-1:0] TEMP_SCALE  = CELSIUS_W'(193);
  localparam logic signed [CELSIUS_W-1:0] TEMP_OFFSET = CELSIUS_W'(2394030);
  localparam logic signed [SUM_W-1:0]     MEAN_BIAS   = SUM_W'(WINDOW_DEPTH - 1);

  typedef enum logic [1:0] {
    CH_TEMP    = 2'd0,
    CH_ACCEL_X = 2'd1,
    CH_ACCEL_Y = 2'd2,
    CH_ACCEL_Z = 2'd3
  } chan_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [TOTAL_W-1:0]  total_t;

  // Members listed from the highest bits down.
  typedef struct packed {
    sample_t gyro_z_raw;
    sample_t gyro_y_raw;
    sample_t gyro_x_raw;
    sample_t accel_z_raw;
    sample_t accel_y_raw;
    sample_t accel_x_raw;
    sample_t temp_raw;
  } frame_t;

  typedef struct packed {
    logic [PAD_W-1:0]             pad;
    total_t                       gyro_z_total;
    total_t                       gyro_y_total;
    total_t                       gyro_x_total;
    sample_t                      accel_z_mean;
    sample_t                      accel_y_mean;
    sample_t                      accel_x_mean;
    logic signed [CELSIUS_W-1:0]  temp_celsius_q16;
    sample_t                      temp_mean;
  } result_t;

  function automatic sample_t window_mean(sum_t sum);
    sum_t biased;
    sum_t shifted;
    biased  = sum + (sum[SUM_W-1] ? MEAN_BIAS : sum_t'(0));
    shifted = biased >>> WINDOW_LOG2;
    return shifted[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [CELSIUS_W-1:0] to_celsius(sample_t mean);
    logic signed [CELSIUS_W-1:0] mean_ext;
    mean_ext = {{(CELSIUS_W - SAMPLE_W){mean[SAMPLE_W-1]}}, mean};
    return mean_ext * TEMP_SCALE + TEMP_OFFSET;
  endfunction

  function automatic total_t scale_gyro(sample_t raw, logic [GAIN_W-1:0] gain);
    logic signed [PROD_W-1:0] raw_ext;
    logic signed [PROD_W-1:0] gain_ext;
    logic signed [PROD_W-1:0] prod;
    raw_ext  = {{(PROD_W - SAMPLE_W){raw[SAMPLE_W-1]}}, raw};
    gain_ext = {{(PROD_W - GAIN_W){1'b0}}, gain};
    prod     = raw_ext * gain_ext;
    return {{(TOTAL_W - PROD_W){prod[PROD_W-1]}}, prod};
  endfunction

endpackage

[rtl/imu_frame_average_integrate_top.sv]
// Top level: 8-deep moving averages of temperature and accel, scaled gyro integration.
//
//  channel  | dir | payload                                    | request taken when
//  ---------+-----+--------------------------------------------+----------------------------
//  s_axis   | in  | tdata: 7 x 16-bit sensor words, tlast      | s_axis_tvalid & s_axis_tready
//  m_axis   | out | tdata: means, 9.16 temp, gyro totals       | m_axis_tvalid & m_axis_tready
//  cfg      | in  | cfg_data_i: gyro gain                      | cfg_valid_i & cfg_ready_o
//
//  One frame per cycle while s_axis_tready is high: running window sums and gyro
//  accumulators absorb a frame in the cycle it is taken; a tlast frame's result goes
//  to the output register, or to a skid register holding one more while the output stalls.
//  Reset clears the windows, sums, accumulators, ring slot and sets the gain to 5.
//  s_axis_tready drops only while both output and skid registers hold results.
module imu_frame_average_integrate_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // temp_raw, accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  logic [imufai_pkg::FRAME_W-1:0]   s_axis_tdata,
  // burst_last
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // temp_mean, temp_celsius_q16, accel_x_mean, accel_y_mean, accel_z_mean,
  // gyro_x_total, gyro_y_total, gyro_z_total, zero fill
  output logic [imufai_pkg::RESULT_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [imufai_pkg::GAIN_W-1:0]    cfg_data_i
);

  localparam int unsigned SlotW = imufai_pkg::WINDOW_LOG2;

  imufai_pkg::frame_t  frame;
  imufai_pkg::sample_t samples [imufai_pkg::NUM_CHAN];
  imufai_pkg::sample_t gyro_raw [imufai_pkg::NUM_GYRO];

  imufai_pkg::sample_t win_q [imufai_pkg::NUM_CHAN][imufai_pkg::WINDOW_DEPTH];
  imufai_pkg::sum_t    sum_q [imufai_pkg::NUM_CHAN];
  imufai_pkg::sum_t    sum_d [imufai_pkg::NUM_CHAN];
  imufai_pkg::total_t  gyro_q [imufai_pkg::NUM_GYRO];
  imufai_pkg::total_t  gyro_d [imufai_pkg::NUM_GYRO];
  logic [SlotW-1:0]    slot_q;
  logic [imufai_pkg::GAIN_W-1:0] gain_q;

  imufai_pkg::result_t res_new;
  imufai_pkg::result_t out_q;
  imufai_pkg::result_t skid_q;
  logic                out_valid_q;
  logic                skid_valid_q;

  logic in_fire;
  logic out_fire;
  logic res_fire;
  logic cfg_fire;

  assign s_axis_tready = !skid_valid_q;
  assign cfg_ready_o   = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;
  assign res_fire      = in_fire && s_axis_tlast;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;

  assign frame = imufai_pkg::frame_t'(s_axis_tdata);

  always_comb begin
    samples[imufai_pkg::CH_TEMP]    = frame.temp_raw;
    samples[imufai_pkg::CH_ACCEL_X] = frame.accel_x_raw;
    samples[imufai_pkg::CH_ACCEL_Y] = frame.accel_y_raw;
    samples[imufai_pkg::CH_ACCEL_Z] = frame.accel_z_raw;
    gyro_raw[0] = frame.gyro_x_raw;
    gyro_raw[1] = frame.gyro_y_raw;
    gyro_raw[2] = frame.gyro_z_raw;
    for (int c = 0; c < imufai_pkg::NUM_CHAN; c++) begin
      sum_d[c] = sum_q[c]
               - imufai_pkg::sum_t'(win_q[c][slot_q])
               + imufai_pkg::sum_t'(samples[c]);
    end
    for (int g = 0; g < imufai_pkg::NUM_GYRO; g++) begin
      gyro_d[g] = gyro_q[g] + imufai_pkg::scale_gyro(gyro_raw[g], gain_q);
    end
  end

  always_comb begin
    res_new                  = '0;
    res_new.temp_mean        = imufai_pkg::window_mean(sum_d[imufai_pkg::CH_TEMP]);
    res_new.temp_celsius_q16 = imufai_pkg::to_celsius(res_new.temp_mean);
    res_new.accel_x_mean     = imufai_pkg::window_mean(sum_d[imufai_pkg::CH_ACCEL_X]);
    res_new.accel_y_mean     = imufai_pkg::window_mean(sum_d[imufai_pkg::CH_ACCEL_Y]);
    res_new.accel_z_mean     = imufai_pkg::window_mean(sum_d[imufai_pkg::CH_ACCEL_Z]);
    res_new.gyro_x_total     = gyro_d[0];
    res_new.gyro_y_total     = gyro_d[1];
    res_new.gyro_z_total     = gyro_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= imufai_pkg::GAIN_RESET;
    end else if (cfg_fire) begin
      gain_q <= cfg_data_i;
    end
  end

  // absorb the frame into windows, running sums and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      for (int c = 0; c < imufai_pkg::NUM_CHAN; c++) begin
        sum_q[c] <= '0;
        for (int e = 0; e < imufai_pkg::WINDOW_DEPTH; e++) begin
          win_q[c][e] <= '0;
        end
      end
      for (int g = 0; g < imufai_pkg::NUM_GYRO; g++) begin
        gyro_q[g] <= '0;
      end
    end else if (in_fire) begin
      slot_q <= slot_q + SlotW'(1);
      for (int c = 0; c < imufai_pkg::NUM_CHAN; c++) begin
        sum_q[c]         <= sum_d[c];
        win_q[c][slot_q] <= samples[c];
      end
      for (int g = 0; g < imufai_pkg::NUM_GYRO; g++) begin
        gyro_q[g] <= gyro_d[g];
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_fire) begin
        out_q <= res_new;
      end
    end else if (res_fire) begin
      skid_q <= res_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_skid_needs_out : assert property (
    @(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q
  ) else $error("skid entry held without an output entry");

  a_stall_fills_skid : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_fire && out_valid_q && !m_axis_tready) |=> skid_valid_q
  ) else $error("result lost while output stalled");

  a_gain_only_on_write : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !cfg_fire |=> $stable(gain_q)
  ) else $error("gain changed without a configuration request");

  a_slot_advances : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> slot_q == $past(slot_q) + SlotW'(1)
  ) else $error("ring slot did not advance on an accepted frame");

endmodule
